// File: hw/rtl/its_pkg.sv
// Shared types, codes and helper functions of the integer text scanner.
`default_nettype none

package its_pkg;

  // Accumulator and character counter widths.
  localparam int ACC_BITS   = 64;
  localparam int COUNT_BITS = 8;

  // Field widths.
  localparam int CH_BITS     = 8;
  localparam int VALUE_BITS  = 64;
  localparam int LIMIT_BITS  = 8;
  localparam int CFG_DATA_BITS  = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int DIGIT_BITS  = 7;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_MODE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_CHARS   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STORE_WIDTH = 2'd2;

  // Base codes.
  localparam logic [1:0] B_AUTO = 2'd0;
  localparam logic [1:0] B_OCT  = 2'd1;
  localparam logic [1:0] B_DEC  = 2'd2;
  localparam logic [1:0] B_HEX  = 2'd3;

  // Store width codes.
  localparam logic [1:0] SW_8  = 2'd0;
  localparam logic [1:0] SW_16 = 2'd1;
  localparam logic [1:0] SW_32 = 2'd2;
  localparam logic [1:0] SW_64 = 2'd3;

  // Parse phases.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_PREFIX = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  // Character codes.
  localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CH_BITS-1:0] CH_UX    = 8'h58;
  localparam logic [CH_BITS-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CH_BITS-1:0] CH_LX    = 8'h78;
  localparam logic [CH_BITS-1:0] CH_LZ    = 8'h7A;

  // Digit value of a byte that is no digit at all.
  localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 7'd99;
  localparam logic [CH_BITS-1:0]    LETTER_OFS = 8'd10;

  typedef struct packed {
    logic [1:0]            base_mode;
    logic [LIMIT_BITS-1:0] max_chars;
    logic [1:0]            store_width;
  } its_cfg_t;

  typedef struct packed {
    logic [2:0]            phase;
    logic [ACC_BITS-1:0]   acc;
    logic                  is_negative;
    logic                  any_digit;
    logic [COUNT_BITS-1:0] chars_used;
    logic [1:0]            active_base;
  } its_state_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  matched;
    logic                  used_char;
  } its_result_t;

  // State of the parser between numbers.
  localparam its_state_t STATE_CLEAR = '{
    phase:       PH_IDLE,
    acc:         '0,
    is_negative: 1'b0,
    any_digit:   1'b0,
    chars_used:  '0,
    active_base: B_DEC
  };

  // Digit value of a character: digits 0..9, letters 10..35, else DIGIT_NONE.
  function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CH_BITS-1:0] c,
                                                     input logic eof);
    logic [CH_BITS-1:0] d;
    d = {1'b0, DIGIT_NONE};
    if (!eof) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
      end else if (c >= CH_LA && c <= CH_LZ) begin
        d = c - CH_LA + LETTER_OFS;
      end else if (c >= CH_UA && c <= CH_UZ) begin
        d = c - CH_UA + LETTER_OFS;
      end
    end
    return d[DIGIT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/its_char_if.sv
// Character input channel: valid/ready handshake with one character or end marker.
`default_nettype none

interface its_char_if;
  import its_pkg::*;

  logic               valid;
  logic               ready;
  logic [CH_BITS-1:0] ch;
  logic               end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/its_result_if.sv
// Result output channel: valid/ready handshake with the parsed value and flags.
`default_nettype none

interface its_result_if;
  import its_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  matched;
  logic                  used_char;

  modport source (output valid, output value, output matched, output used_char,
                  input ready);
  modport sink   (input valid, input value, input matched, input used_char,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/its_cfg.sv
// Configuration register file of the integer text scanner.
`default_nettype none

module its_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [its_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [its_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output its_pkg::its_cfg_t                       cfg
);
  import its_pkg::*;

  its_cfg_t regs;

  // Register writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.base_mode   <= B_DEC;
      regs.max_chars   <= '0;
      regs.store_width <= SW_32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_MODE:   regs.base_mode   <= cfg_data[1:0];
        REG_MAX_CHARS:   regs.max_chars   <= cfg_data[LIMIT_BITS-1:0];
        REG_STORE_WIDTH: regs.store_width <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;
endmodule

`default_nettype wire

// File: hw/rtl/its_step.sv
// Next-state and result logic for one character of the integer text scanner.
`default_nettype none

module its_step (
  input  wire its_pkg::its_cfg_t            cfg,
  input  wire its_pkg::its_state_t          st,
  input  wire logic [its_pkg::CH_BITS-1:0]  ch,
  input  wire logic                         eof,
  output its_pkg::its_state_t               st_next,
  output logic                              fire,
  output its_pkg::its_result_t              result
);
  import its_pkg::*;

  localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

  // True while the number may still take another character.
  function automatic logic room(input logic [COUNT_BITS-1:0] n,
                                input logic [LIMIT_BITS-1:0] lim);
    return (lim == '0) || (CMP_BITS'(n) < CMP_BITS'(lim));
  endfunction

  // Character counter that sticks at its top value.
  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] n);
    return (n == '1) ? n : n + 1'b1;
  endfunction

  logic [DIGIT_BITS-1:0] d;
  logic [DIGIT_BITS-1:0] r;
  logic [2:0]            ph;
  logic [1:0]            ab;
  logic [COUNT_BITS-1:0] cnt;
  logic [ACC_BITS-1:0]   acc_v;
  logic [ACC_BITS-1:0]   acc_mul;
  logic                  neg;
  logic                  anyd;
  logic                  done;
  logic                  go_digits;
  logic                  fin;
  logic                  fin_ok;
  logic                  fin_used;
  logic [VALUE_BITS-1:0] acc64;
  logic [VALUE_BITS-1:0] signed_v;
  logic [VALUE_BITS-1:0] masked_v;

  assign d = digit_of(ch, eof);

  // Walk the parse phases for this character.
  always_comb begin
    ph        = st.phase;
    ab        = st.active_base;
    cnt       = st.chars_used;
    acc_v     = st.acc;
    neg       = st.is_negative;
    anyd      = st.any_digit;
    done      = 1'b0;
    go_digits = 1'b0;
    fin       = 1'b0;
    fin_ok    = 1'b0;
    fin_used  = 1'b0;
    acc_mul   = '0;
    r         = DIGIT_BITS'(10);

    // First character of a number: sample the base and look for a sign.
    if (ph == PH_IDLE) begin
      ab = cfg.base_mode;
      if (!eof && (ch == CH_MINUS || ch == CH_PLUS)) begin
        neg  = (ch == CH_MINUS);
        cnt  = bump(cnt);
        done = 1'b1;
        if (!room(cnt, cfg.max_chars)) begin
          fin      = 1'b1;
          fin_used = 1'b1;
        end else begin
          ph = PH_SIGN;
        end
      end else begin
        ph = PH_SIGN;
      end
    end

    // Leading zero, prefix and limit handling.
    if (!done) begin
      case (ph)
        PH_SIGN: begin
          if (!eof && ch == CH_ZERO) begin
            anyd = 1'b1;
            cnt  = bump(cnt);
            done = 1'b1;
            if (!room(cnt, cfg.max_chars)) begin
              fin      = 1'b1;
              fin_ok   = 1'b1;
              fin_used = 1'b1;
            end else begin
              ph = PH_ZERO;
            end
          end else begin
            if (ab == B_AUTO) ab = B_DEC;
            go_digits = 1'b1;
          end
        end
        PH_ZERO: begin
          if (!eof && (ch == CH_LX || ch == CH_UX) && (ab == B_HEX || ab == B_AUTO)) begin
            ab   = B_HEX;
            cnt  = bump(cnt);
            anyd = 1'b0;
            ph   = PH_PREFIX;
            done = 1'b1;
          end else begin
            if (ab == B_AUTO) ab = B_OCT;
            go_digits = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (d >= DIGIT_BITS'(16)) begin
            // Prefix with no hex digit after it: only the zero matched.
            acc_v  = '0;
            fin    = 1'b1;
            fin_ok = 1'b1;
            done   = 1'b1;
          end else if (!room(cnt, cfg.max_chars)) begin
            fin  = 1'b1;
            done = 1'b1;
          end else begin
            go_digits = 1'b1;
          end
        end
        PH_DIGITS: go_digits = 1'b1;
        default: done = 1'b1;
      endcase
    end

    // Digit accumulation in the active base.
    if (!done && go_digits) begin
      case (ab)
        B_OCT: begin
          r       = DIGIT_BITS'(8);
          acc_mul = acc_v << 3;
        end
        B_HEX: begin
          r       = DIGIT_BITS'(16);
          acc_mul = acc_v << 4;
        end
        default: begin
          r       = DIGIT_BITS'(10);
          acc_mul = (acc_v << 3) + (acc_v << 1);
        end
      endcase
      if (d < r) begin
        acc_v = acc_mul + ACC_BITS'(d);
        anyd  = 1'b1;
        cnt   = bump(cnt);
        ph    = PH_DIGITS;
        if (!room(cnt, cfg.max_chars)) begin
          fin      = 1'b1;
          fin_ok   = 1'b1;
          fin_used = 1'b1;
        end
      end else begin
        fin    = 1'b1;
        fin_ok = anyd;
      end
    end
  end

  // Sign and store width applied to the finished value.
  always_comb begin
    acc64    = VALUE_BITS'(acc_v);
    signed_v = neg ? (VALUE_BITS'(0) - acc64) : acc64;
    case (cfg.store_width)
      SW_8:    masked_v = {56'd0, signed_v[7:0]};
      SW_16:   masked_v = {48'd0, signed_v[15:0]};
      SW_32:   masked_v = {32'd0, signed_v[31:0]};
      default: masked_v = signed_v;
    endcase
  end

  // A finished number returns the parser to its idle state.
  always_comb begin
    if (fin || (st.phase != PH_IDLE && st.phase != PH_SIGN && st.phase != PH_ZERO &&
                st.phase != PH_PREFIX && st.phase != PH_DIGITS)) begin
      st_next = STATE_CLEAR;
    end else begin
      st_next.phase       = ph;
      st_next.acc         = acc_v;
      st_next.is_negative = neg;
      st_next.any_digit   = anyd;
      st_next.chars_used  = cnt;
      st_next.active_base = ab;
    end
  end

  assign fire             = fin;
  assign result.value     = fin_ok ? masked_v : '0;
  assign result.matched   = fin_ok;
  assign result.used_char = fin_used;
endmodule

`default_nettype wire

// File: hw/rtl/integer_text_scanner_top.sv
// Top level of the integer text scanner: input register, parse step, result register.
// A transferred character waits in the input register; its result (if any) enters the result register as it moves on.
// Throughput: one character per cycle while the result side keeps taking transfers.
// The parse state is updated by the single step unit between the two registers.
// Reset (rst, synchronous, active high) empties both registers, clears the parse
// state and loads the default configuration: decimal, no limit, 32-bit store.
`default_nettype none

module integer_text_scanner_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [its_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [its_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  its_char_if.sink                                chr,
  its_result_if.source                            res
);
  import its_pkg::*;

  its_cfg_t            cfg;
  its_state_t          st;
  its_state_t          st_next;
  its_result_t         step_res;
  logic                step_fire;
  logic                in_valid;
  logic [CH_BITS-1:0]  in_ch;
  logic                in_eof;
  logic                advance;
  logic                res_valid;
  its_result_t         res_data;

  its_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  its_step u_step (
    .cfg     (cfg),
    .st      (st),
    .ch      (in_ch),
    .eof     (in_eof),
    .st_next (st_next),
    .fire    (step_fire),
    .result  (step_res)
  );

  // The held character moves on when the result register has room.
  assign advance   = in_valid && (!res_valid || res.ready);
  assign chr.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chr.ready) begin
      in_valid <= chr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chr.valid && chr.ready) begin
      in_ch  <= chr.ch;
      in_eof <= chr.end_of_input;
    end
  end

  // Parse state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_CLEAR;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && step_fire) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_fire) begin
      res_data <= step_res;
    end
  end

  assign res.valid     = res_valid;
  assign res.value     = res_data.value;
  assign res.matched   = res_data.matched;
  assign res.used_char = res_data.used_char;
endmodule

`default_nettype wire

// File: hw/rtl/its_checker.sv
// Port-level checks of the integer text scanner, bound to the top level.
`default_nettype none

module its_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        chr_valid,
  input wire logic        chr_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [63:0] value,
  input wire logic        matched
);

  // A failed match always reports a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !matched |-> value == 64'd0)
    else $error("failed match with nonzero value");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result pending after reset");

  // A new result follows a character transfer.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    res_valid && !$past(res_valid) |-> $past(chr_valid && chr_ready, 2))
    else $error("result without a preceding character transfer");

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(value))
    else $error("stalled result changed");

endmodule

bind integer_text_scanner_top its_checker u_its_checker (
  .clk       (clk),
  .rst       (rst),
  .chr_valid (chr.valid),
  .chr_ready (chr.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .value     (res.value),
  .matched   (res.matched)
);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench of the integer text scanner: directed and random character streams.
module tb_top;
  import its_pkg::*;

  // Run limits and pacing.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 95;
  localparam int RANDOM_PHASES = 12;
  localparam int LONG_STALL    = 200;

  // Register index that no register answers to.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  // Characters used by the stimulus beyond those of the package.
  localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [CH_BITS-1:0] ch;
    logic               eoi;
  } char_item_t;

  logic clk;
  logic rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  its_char_if   chr_if ();
  its_result_if res_if ();

  integer_text_scanner_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chr       (chr_if),
    .res       (res_if)
  );

  // Characters waiting to be offered and numbers expected back.
  char_item_t  char_queue[$];
  its_result_t scan_results[$];
  char_item_t  offered;

  int unsigned items_queued;
  int unsigned items_accepted;
  int unsigned results_seen;
  int unsigned matches_seen;
  int unsigned errors;
  int unsigned cycle_count;
  int unsigned phases_run;

  // Idling controls shared by the driver and the monitor.
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  bit          stall_burst_armed;
  bit          stall_burst_done;
  int unsigned stall_left;

  // Configuration as the scanner holds it.
  logic [1:0]            cfg_base_mode;
  logic [LIMIT_BITS-1:0] cfg_limit;
  logic [1:0]            cfg_width;

  // Parser state of the prediction.
  logic [2:0]            ps_phase;
  logic [ACC_BITS-1:0]   ps_acc;
  logic                  ps_neg;
  logic                  ps_any;
  logic [COUNT_BITS-1:0] ps_count;
  logic [1:0]            ps_base;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Digit weight of a byte, or DIGIT_NONE for anything that is no digit.
  function automatic logic [6:0] char_digit(input logic [7:0] c, input logic eoi);
    if (eoi) return DIGIT_NONE;
    if (c >= "0" && c <= "9") return 7'(c - "0");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 10);
    if (c >= "A" && c <= "Z") return 7'(c - "A" + 10);
    return DIGIT_NONE;
  endfunction

  function automatic logic [4:0] base_radix(input logic [1:0] b);
    if (b == B_OCT) return 5'd8;
    if (b == B_HEX) return 5'd16;
    return 5'd10;
  endfunction

  function automatic bit has_room();
    return cfg_limit == '0 || ps_count < cfg_limit;
  endfunction

  // The character counter saturates at its top value.
  task automatic count_char();
    if (ps_count != '1) ps_count = ps_count + 1'b1;
  endtask

  task automatic clear_number();
    ps_phase = PH_IDLE;
    ps_acc   = '0;
    ps_neg   = 1'b0;
    ps_any   = 1'b0;
    ps_count = '0;
    ps_base  = B_DEC;
  endtask

  // Close the number: sign it, cut it to the store width and queue the result.
  task automatic finish_number(input bit ok, input bit used);
    its_result_t r;
    logic [63:0] v;
    v = '0;
    if (ok) begin
      v = ps_neg ? (64'd0 - ps_acc) : ps_acc;
      case (cfg_width)
        SW_8:    v = v & 64'hFF;
        SW_16:   v = v & 64'hFFFF;
        SW_32:   v = v & 64'hFFFF_FFFF;
        default: v = v;
      endcase
    end
    r.value     = v;
    r.matched   = ok;
    r.used_char = used;
    scan_results.push_back(r);
    clear_number();
  endtask

  // Advance the predicted parser by one transferred character.
  task automatic scan_char(input logic [7:0] c, input logic eoi);
    logic [6:0]  d;
    logic [63:0] r;
    d = char_digit(c, eoi);
    if (ps_phase == PH_IDLE) begin
      ps_base = cfg_base_mode;
      if (!eoi && (c == CH_MINUS || c == CH_PLUS)) begin
        ps_neg = (c == CH_MINUS);
        count_char();
        if (!has_room()) finish_number(1'b0, 1'b1);
        else ps_phase = PH_SIGN;
        return;
      end
      ps_phase = PH_SIGN;
    end
    if (ps_phase == PH_SIGN) begin
      if (!eoi && c == CH_ZERO) begin
        ps_any = 1'b1;
        count_char();
        if (!has_room()) finish_number(1'b1, 1'b1);
        else ps_phase = PH_ZERO;
        return;
      end
      if (ps_base == B_AUTO) ps_base = B_DEC;
      ps_phase = PH_DIGITS;
    end else if (ps_phase == PH_ZERO) begin
      // A leading zero followed by x opens a hex number where the base allows it.
      if (!eoi && (c == CH_LX || c == CH_UX) && (ps_base == B_HEX || ps_base == B_AUTO)) begin
        ps_base = B_HEX;
        count_char();
        ps_any   = 1'b0;
        ps_phase = PH_PREFIX;
        return;
      end
      if (ps_base == B_AUTO) ps_base = B_OCT;
      ps_phase = PH_DIGITS;
    end else if (ps_phase == PH_PREFIX) begin
      // After the prefix the next character decides, even at the limit.
      if (d >= 7'd16) begin
        ps_acc = '0;
        finish_number(1'b1, 1'b0);
        return;
      end
      if (!has_room()) begin
        finish_number(1'b0, 1'b0);
        return;
      end
      ps_phase = PH_DIGITS;
    end else if (ps_phase != PH_DIGITS) begin
      clear_number();
      return;
    end
    r = 64'(base_radix(ps_base));
    if (64'(d) < r) begin
      ps_acc = ps_acc * r + 64'(d);
      ps_any = 1'b1;
      count_char();
      if (!has_room()) finish_number(1'b1, 1'b1);
    end else begin
      finish_number(ps_any, 1'b0);
    end
  endtask

  // Driver: offers queued characters and predicts each transfer.
  always @(posedge clk) begin
    if (rst) begin
      chr_if.valid        <= 1'b0;
      chr_if.ch           <= '0;
      chr_if.end_of_input <= 1'b0;
    end else begin
      if (chr_if.valid && chr_if.ready) begin
        scan_char(chr_if.ch, chr_if.end_of_input);
        items_accepted++;
      end
      if (!chr_if.valid || chr_if.ready) begin
        if (char_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered = char_queue.pop_front();
          chr_if.valid        <= 1'b1;
          chr_if.ch           <= offered.ch;
          chr_if.end_of_input <= offered.eoi;
        end else begin
          chr_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    its_result_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (res_if.matched) matches_seen++;
        if (scan_results.size() == 0) begin
          $display("%0t: unexpected result value=%h matched=%b used_char=%b", $time,
                   res_if.value, res_if.matched, res_if.used_char);
          errors++;
        end else begin
          want = scan_results.pop_front();
          if (res_if.value !== want.value) begin
            $display("%0t: value expected %h actual %h", $time, want.value, res_if.value);
            errors++;
          end
          if (res_if.matched !== want.matched) begin
            $display("%0t: matched expected %b actual %b", $time, want.matched,
                     res_if.matched);
            errors++;
          end
          if (res_if.used_char !== want.used_char) begin
            $display("%0t: used_char expected %b actual %b", $time, want.used_char,
                     res_if.used_char);
            errors++;
          end
        end
      end
      // One long hold-off lets the scanner fill up and stall its input.
      if (stall_burst_armed && !stall_burst_done) begin
        stall_burst_done = 1'b1;
        stall_left = LONG_STALL;
      end
      if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, scan_results.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] c, input logic eoi);
    char_item_t it;
    it.ch  = c;
    it.eoi = eoi;
    char_queue.push_back(it);
    items_queued++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endtask

  // A random digit of the given base, letters in either case.
  function automatic logic [7:0] digit_char(input logic [1:0] b);
    int unsigned v;
    v = $urandom_range(base_radix(b) - 1);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  // A well-formed number with random content and a random ending.
  task automatic push_number();
    int unsigned k;
    int unsigned n;
    logic [1:0]  b;
    k = $urandom_range(9);
    if (k < 2) push_item(CH_MINUS, 1'b0);
    else if (k < 3) push_item(CH_PLUS, 1'b0);
    b = cfg_base_mode;
    k = $urandom_range(9);
    if ((b == B_AUTO || b == B_HEX) && k < 4) begin
      push_item(CH_ZERO, 1'b0);
      push_item($urandom_range(1) ? CH_LX : CH_UX, 1'b0);
      b = B_HEX;
    end else if (b == B_AUTO && k < 7) begin
      push_item(CH_ZERO, 1'b0);
      b = B_OCT;
    end else if (k == 9) begin
      // A stray prefix in a fixed base, or a bare zero.
      push_item(CH_ZERO, 1'b0);
      if ($urandom_range(1)) push_item(CH_LX, 1'b0);
    end
    if (b == B_AUTO) b = B_DEC;
    n = ($urandom_range(9) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 8);
    repeat (n) push_item(digit_char(b), 1'b0);
    k = $urandom_range(9);
    if (k < 3) push_item(8'($urandom_range(255)), 1'b1);
    else if (k < 6) push_item(CH_SPACE, 1'b0);
    else if (k < 9) push_item(8'($urandom_range(255)), 1'b0);
  endtask

  // Register write; the prediction takes the new value at the same edge.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BASE_MODE:   cfg_base_mode = data[1:0];
      REG_MAX_CHARS:   cfg_limit     = data;
      REG_STORE_WIDTH: cfg_width     = data[1:0];
      default:         cfg_limit     = cfg_limit;
    endcase
  endtask

  // Write all three registers; upper data bits of the base and width writes are noise the scanner must drop.
  task automatic write_config(input logic [1:0] b, input logic [7:0] lim,
                              input logic [1:0] w);
    write_reg(REG_BASE_MODE, {6'($urandom_range(63)), b});
    write_reg(REG_MAX_CHARS, lim);
    write_reg(REG_STORE_WIDTH, {6'($urandom_range(63)), w});
  endtask

  // Wait until every queued character has moved and every result has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (items_accepted != items_queued || scan_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Idling pattern by number: none, sender, receiver, both.
  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
      default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
    endcase
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    int unsigned p;
    int unsigned start;
    logic [7:0]  lim;
    chr_if.valid        = 1'b0;
    chr_if.ch           = '0;
    chr_if.end_of_input = 1'b0;
    res_if.ready        = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst       = 1'b1;
    items_queued   = 0;
    items_accepted = 0;
    results_seen   = 0;
    matches_seen   = 0;
    errors         = 0;
    cycle_count    = 0;
    phases_run     = 0;
    stall_burst_armed = 1'b0;
    stall_burst_done  = 1'b0;
    stall_left        = 0;
    cfg_base_mode = B_DEC;
    cfg_limit     = '0;
    cfg_width     = SW_32;
    clear_number();
    set_idling(0);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Default configuration straight out of reset.
    push_text("-123 ");
    wait_drained();

    // Automatic base, no limit, full width: prefixes, signs and empty input.
    write_config(B_AUTO, 8'd0, SW_64);
    write_reg(REG_SPARE, 8'hFF);
    push_text("0x1F");
    push_item(8'hFF, 1'b1);
    push_text("0xg-017 + ");
    push_item(8'h00, 1'b1);
    push_text("08-9z");
    wait_drained();

    // A limit of two: hex digit after the prefix, sign and digit at the limit.
    write_reg(REG_MAX_CHARS, 8'd2);
    push_text("0xA-10X");
    push_item(CH_ZERO, 1'b1);
    wait_drained();

    // A limit of one: lone sign and single digit.
    write_reg(REG_MAX_CHARS, 8'd1);
    push_text("+7");
    wait_drained();

    // Random phases over several settings and every idling pattern.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: write_config(B_AUTO, 8'd0, SW_64);
        1: write_config(B_HEX, 8'd255, SW_8);
        2: write_config(B_OCT, 8'd1, SW_16);
        3: write_config(B_DEC, 8'd0, SW_32);
        default: begin
          case ($urandom_range(3))
            0, 1: lim = 8'd0;
            2: lim = 8'($urandom_range(1, 6));
            default: lim = 8'($urandom_range(255));
          endcase
          write_config(2'($urandom_range(3)), lim, 2'($urandom_range(3)));
        end
      endcase
      set_idling(p % 4);
      if (p == 0) stall_burst_armed = 1'b1;
      // Very long numbers: counter saturation without a limit, the top limit otherwise.
      if (p < 2) begin
        repeat (300) push_item(digit_char(cfg_base_mode == B_AUTO ? B_DEC : cfg_base_mode),
                               1'b0);
        push_item(CH_SPACE, 1'b0);
      end
      start = items_queued;
      while (items_queued - start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 85) push_number();
        else push_item(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
      wait_drained();
      phases_run++;
    end

    if (scan_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, scan_results.size());
      errors++;
    end
    $display("Scanned %0d characters into %0d numbers (%0d matched) over %0d random phases,",
             items_accepted, results_seen, matches_seen, phases_run);
    $display("covering all bases, store widths, limits and idling patterns.");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/its_pkg.sv
hw/rtl/its_char_if.sv
hw/rtl/its_result_if.sv
hw/rtl/its_cfg.sv
hw/rtl/its_step.sv
hw/rtl/integer_text_scanner_top.sv
hw/rtl/its_checker.sv
tb/tb_top.sv
